// ===== hdl/pjd_pkg.sv =====
// Shared widths, register codes, CORDIC arctangent table and interface types of the pose jump detector.
package pjd_pkg;

    localparam int POS_W       = 31;
    localparam int HEAD_W      = 16;
    localparam int YAW_LIMIT_W = 16;
    localparam int LIMIT_W     = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int MUL_W   = 32;
    localparam int FRAC_W  = 30;
    localparam int TRIG_W  = 31;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int CORDIC_XY_W      = 33;
    localparam int CORDIC_Z_W       = 34;

    localparam logic [CORDIC_XY_W-1:0] CORDIC_X0  = CORDIC_XY_W'(652032874);
    localparam logic [CORDIC_XY_W-1:0] CORDIC_ONE = CORDIC_XY_W'(1 << FRAC_W);

    localparam logic [HEAD_W-1:0] HALF_TURN    = 16'h8000;
    localparam logic [HEAD_W-2:0] QUARTER_TURN = 15'h4000;

    localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATERAL_LIMIT = 2'd2;

    localparam logic [YAW_LIMIT_W-1:0] YAW_LIMIT_RST     = 16'd1820;
    localparam logic [LIMIT_W-1:0]     FORWARD_LIMIT_RST = 31'd2048;
    localparam logic [LIMIT_W-1:0]     LATERAL_LIMIT_RST = 31'd2048;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic [TRIG_W-1:0] cos_mag;
        logic [TRIG_W-1:0] sin_mag;
    } trig_t;

    // Rounded atan(2^-i) with a half turn equal to 2^31.
    function automatic logic [CORDIC_Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [CORDIC_Z_W-1:0] val;
        unique case (idx)
            5'd0:    val = CORDIC_Z_W'(536870912);
            5'd1:    val = CORDIC_Z_W'(316933406);
            5'd2:    val = CORDIC_Z_W'(167458907);
            5'd3:    val = CORDIC_Z_W'(85004756);
            5'd4:    val = CORDIC_Z_W'(42667331);
            5'd5:    val = CORDIC_Z_W'(21354465);
            5'd6:    val = CORDIC_Z_W'(10679838);
            5'd7:    val = CORDIC_Z_W'(5340245);
            5'd8:    val = CORDIC_Z_W'(2670163);
            5'd9:    val = CORDIC_Z_W'(1335087);
            5'd10:   val = CORDIC_Z_W'(667544);
            5'd11:   val = CORDIC_Z_W'(333772);
            5'd12:   val = CORDIC_Z_W'(166886);
            5'd13:   val = CORDIC_Z_W'(83443);
            5'd14:   val = CORDIC_Z_W'(41722);
            5'd15:   val = CORDIC_Z_W'(20861);
            5'd16:   val = CORDIC_Z_W'(10430);
            5'd17:   val = CORDIC_Z_W'(5215);
            5'd18:   val = CORDIC_Z_W'(2608);
            5'd19:   val = CORDIC_Z_W'(1304);
            5'd20:   val = CORDIC_Z_W'(652);
            5'd21:   val = CORDIC_Z_W'(326);
            5'd22:   val = CORDIC_Z_W'(163);
            5'd23:   val = CORDIC_Z_W'(81);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/pose_jump_detector.sv =====
// Top level of the pose jump detector: sequencer, pose history, limits and result register.
//
// Poses arrive as beats on the input channel (in_valid / in_ready) and each one
// produces exactly one result beat on the output channel (out_valid / out_ready)
// carrying jump, yaw_over, forward_over and lateral_over. The limits are written
// through cfg_we / cfg_index / cfg_wdata; the user must write them only while
// the block is idle, which the block does not enforce. Unknown indices are ignored.
//
// Each pose is handled on its own: a new pose is taken only after the result
// of the previous one has gone into the output register. Most of the work is
// the 32-step square root of dx^2 + dy^2, which follows two squarings on the
// shared multiplier; the CORDIC for |cos| and |sin| of the previous heading
// runs alongside it, and two more products on the same multiplier finish the
// item.
//
// The result sits in an output register, so a stalled receiver does not hold
// up the next input beat; only when a second result is ready before the first
// has been taken does the sequencer wait. Reset restores the limit defaults,
// clears the pose history so that the first pose is compared with itself, and
// empties the output register.
module pose_jump_detector
#(
    parameter int CORDIC_STEPS = pjd_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [pjd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pjd_pkg::CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [pjd_pkg::POS_W-1:0]     pos_x,
    input  logic signed [pjd_pkg::POS_W-1:0]     pos_y,
    input  logic signed [pjd_pkg::HEAD_W-1:0]    heading,
    input  logic                                 pose_valid,
    input  logic                                 dead_reckon_too_long,
    input  logic                                 from_wheel,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 jump,
    output logic                                 yaw_over,
    output logic                                 forward_over,
    output logic                                 lateral_over
);

    localparam int POS_W  = pjd_pkg::POS_W;
    localparam int DX_W   = POS_W + 1;
    localparam int MUL_W  = pjd_pkg::MUL_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int HI_W   = PROD_W - pjd_pkg::FRAC_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQX  = 9'b000000010,
        S_SQY  = 9'b000000100,
        S_ADD  = 9'b000001000,
        S_ROOT = 9'b000010000,
        S_MC   = 9'b000100000,
        S_MS   = 9'b001000000,
        S_ML   = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Limits.
    logic [pjd_pkg::YAW_LIMIT_W-1:0] yaw_limit_reg, yaw_limit_next;
    logic [pjd_pkg::LIMIT_W-1:0]     fwd_limit_reg, fwd_limit_next;
    logic [pjd_pkg::LIMIT_W-1:0]     lat_limit_reg, lat_limit_next;

    // Pose history.
    logic signed [POS_W-1:0]     prev_x_reg, prev_x_next;
    logic signed [POS_W-1:0]     prev_y_reg, prev_y_next;
    logic [pjd_pkg::HEAD_W-1:0]  prev_heading_reg, prev_heading_next;
    logic                        prev_valid_reg, prev_valid_next;
    logic                        prev_too_long_reg, prev_too_long_next;
    logic                        prev_from_wheel_reg, prev_from_wheel_next;
    logic                        primed_reg, primed_next;

    // Working values of the item in flight.
    logic [POS_W-1:0]            ax_reg, ax_next;
    logic [POS_W-1:0]            ay_reg, ay_next;
    logic [pjd_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                        yaw_reg, yaw_next;
    logic                        fwd_reg, fwd_next;
    logic                        lat_reg, lat_next;
    logic                        bypass_reg, bypass_next;

    // Result register.
    logic out_valid_reg, out_valid_next;
    logic jump_reg, jump_next;
    logic yaw_over_reg, yaw_over_next;
    logic forward_over_reg, forward_over_next;
    logic lateral_over_reg, lateral_over_next;

    logic accept;
    logic load_out;

    logic signed [POS_W-1:0]     eff_x;
    logic signed [POS_W-1:0]     eff_y;
    logic [pjd_pkg::HEAD_W-1:0]  eff_heading;
    logic                        eff_valid;
    logic                        eff_too_long;
    logic                        eff_from_wheel;
    logic signed [DX_W-1:0]      dx;
    logic signed [DX_W-1:0]      dy;
    logic [DX_W-1:0]             dx_abs;
    logic [DX_W-1:0]             dy_abs;
    logic [pjd_pkg::HEAD_W-1:0]  dh;
    logic [pjd_pkg::HEAD_W-1:0]  dh_fold;

    logic [MUL_W-1:0]            mul_a;
    logic [MUL_W-1:0]            mul_b;
    logic [PROD_W-1:0]           product;
    logic [HI_W-1:0]             product_hi;

    pjd_pkg::sqrt_req_t          sqrt_req;
    logic                        sqrt_done;
    logic [pjd_pkg::ROOT_W-1:0]  span;
    logic                        cordic_done;
    pjd_pkg::trig_t              trig;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Before the first pose the history is taken to be the pose itself.
    always_comb
    begin
        eff_x          = primed_reg ? prev_x_reg          : pos_x;
        eff_y          = primed_reg ? prev_y_reg          : pos_y;
        eff_heading    = primed_reg ? prev_heading_reg    : $unsigned(heading);
        eff_valid      = primed_reg ? prev_valid_reg      : pose_valid;
        eff_too_long   = primed_reg ? prev_too_long_reg   : dead_reckon_too_long;
        eff_from_wheel = primed_reg ? prev_from_wheel_reg : from_wheel;

        dx     = DX_W'(pos_x) - DX_W'(eff_x);
        dy     = DX_W'(pos_y) - DX_W'(eff_y);
        dx_abs = dx[DX_W-1] ? $unsigned(-dx) : $unsigned(dx);
        dy_abs = dy[DX_W-1] ? $unsigned(-dy) : $unsigned(dy);

        // Shortest way round the circle.
        dh      = $unsigned(heading) - eff_heading;
        dh_fold = (dh > pjd_pkg::HALF_TURN) ? (pjd_pkg::HEAD_W'(0) - dh) : dh;
    end

    // Shared multiplier operands, chosen by the sequencer state.
    always_comb
    begin
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            S_SQY:
            begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
            end
            S_MC:
            begin
                mul_a = span;
                mul_b = MUL_W'(trig.cos_mag);
            end
            S_MS:
            begin
                mul_a = span;
                mul_b = MUL_W'(trig.sin_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product_hi = product[PROD_W-1:pjd_pkg::FRAC_W];

    assign sqrt_req.start    = (state_reg == S_ADD);
    assign sqrt_req.radicand = sum_reg + product;

    always_comb
    begin
        state_next           = state_reg;
        yaw_limit_next       = yaw_limit_reg;
        fwd_limit_next       = fwd_limit_reg;
        lat_limit_next       = lat_limit_reg;
        prev_x_next          = prev_x_reg;
        prev_y_next          = prev_y_reg;
        prev_heading_next    = prev_heading_reg;
        prev_valid_next      = prev_valid_reg;
        prev_too_long_next   = prev_too_long_reg;
        prev_from_wheel_next = prev_from_wheel_reg;
        primed_next          = primed_reg;
        ax_next              = ax_reg;
        ay_next              = ay_reg;
        sum_next             = sum_reg;
        yaw_next             = yaw_reg;
        fwd_next             = fwd_reg;
        lat_next             = lat_reg;
        bypass_next          = bypass_reg;
        out_valid_next       = out_valid_reg;
        jump_next            = jump_reg;
        yaw_over_next        = yaw_over_reg;
        forward_over_next    = forward_over_reg;
        lateral_over_next    = lateral_over_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                pjd_pkg::REG_YAW_LIMIT:     yaw_limit_next = cfg_wdata[pjd_pkg::YAW_LIMIT_W-1:0];
                pjd_pkg::REG_FORWARD_LIMIT: fwd_limit_next = cfg_wdata[pjd_pkg::LIMIT_W-1:0];
                pjd_pkg::REG_LATERAL_LIMIT: lat_limit_next = cfg_wdata[pjd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ax_next  = dx_abs[POS_W-1:0];
                    ay_next  = dy_abs[POS_W-1:0];
                    yaw_next = dh_fold > yaw_limit_reg;
                    // Recovery from dead reckoning onto a fresh code pose is never a jump.
                    bypass_next = !eff_valid && eff_too_long && eff_from_wheel &&
                                  pose_valid && !from_wheel;
                    prev_x_next          = pos_x;
                    prev_y_next          = pos_y;
                    prev_heading_next    = $unsigned(heading);
                    prev_valid_next      = pose_valid;
                    prev_too_long_next   = dead_reckon_too_long;
                    prev_from_wheel_next = from_wheel;
                    primed_next          = 1'b1;
                    state_next           = S_SQX;
                end
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sum_next   = product;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sqrt_done && cordic_done)
                    state_next = S_MC;
            end
            S_MC:
            begin
                state_next = S_MS;
            end
            S_MS:
            begin
                fwd_next   = product_hi > HI_W'(fwd_limit_reg);
                state_next = S_ML;
            end
            S_ML:
            begin
                lat_next   = product_hi > HI_W'(lat_limit_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next    = 1'b1;
                    yaw_over_next     = yaw_reg && !bypass_reg;
                    forward_over_next = fwd_reg && !bypass_reg;
                    lateral_over_next = lat_reg && !bypass_reg;
                    jump_next         = (yaw_reg || fwd_reg || lat_reg) && !bypass_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            yaw_limit_reg       <= pjd_pkg::YAW_LIMIT_RST;
            fwd_limit_reg       <= pjd_pkg::FORWARD_LIMIT_RST;
            lat_limit_reg       <= pjd_pkg::LATERAL_LIMIT_RST;
            prev_x_reg          <= '0;
            prev_y_reg          <= '0;
            prev_heading_reg    <= '0;
            prev_valid_reg      <= 1'b0;
            prev_too_long_reg   <= 1'b0;
            prev_from_wheel_reg <= 1'b0;
            primed_reg          <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            yaw_limit_reg       <= yaw_limit_next;
            fwd_limit_reg       <= fwd_limit_next;
            lat_limit_reg       <= lat_limit_next;
            prev_x_reg          <= prev_x_next;
            prev_y_reg          <= prev_y_next;
            prev_heading_reg    <= prev_heading_next;
            prev_valid_reg      <= prev_valid_next;
            prev_too_long_reg   <= prev_too_long_next;
            prev_from_wheel_reg <= prev_from_wheel_next;
            primed_reg          <= primed_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg           <= ax_next;
        ay_reg           <= ay_next;
        sum_reg          <= sum_next;
        yaw_reg          <= yaw_next;
        fwd_reg          <= fwd_next;
        lat_reg          <= lat_next;
        bypass_reg       <= bypass_next;
        jump_reg         <= jump_next;
        yaw_over_reg     <= yaw_over_next;
        forward_over_reg <= forward_over_next;
        lateral_over_reg <= lateral_over_next;
    end

    pjd_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    pjd_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .done  (sqrt_done),
        .root  (span)
    );

    // The CORDIC works on the previous heading, started as the pose is taken.
    pjd_cordic
    #(
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .angle (eff_heading),
        .done  (cordic_done),
        .trig  (trig)
    );

    assign out_valid    = out_valid_reg;
    assign jump         = jump_reg;
    assign yaw_over     = yaw_over_reg;
    assign forward_over = forward_over_reg;
    assign lateral_over = lateral_over_reg;

endmodule

// ===== hdl/pjd_mul.sv =====
// Shared unsigned multiplier with a registered product.
module pjd_mul
(
    input  logic                          clk,
    input  logic [pjd_pkg::MUL_W-1:0]     a,
    input  logic [pjd_pkg::MUL_W-1:0]     b,
    output logic [2*pjd_pkg::MUL_W-1:0]   product
);

    logic [2*pjd_pkg::MUL_W-1:0] product_reg;
    logic [2*pjd_pkg::MUL_W-1:0] product_next;

    always_comb
    begin
        product_next = a * b;
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

// ===== hdl/pjd_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module pjd_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pjd_pkg::sqrt_req_t            req,
    output logic                          done,
    output logic [pjd_pkg::ROOT_W-1:0]    root
);

    localparam int REM_W = pjd_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(pjd_pkg::ROOT_W);

    logic [pjd_pkg::SUM_W-1:0]  op_reg,   op_next;
    logic [REM_W-1:0]           rem_reg,  rem_next;
    logic [pjd_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]           cnt_reg,  cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [REM_W-1:0]           rem_shift;
    logic [REM_W-1:0]           trial;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], op_reg[pjd_pkg::SUM_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start)
        begin
            op_next   = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            op_next = {op_reg[pjd_pkg::SUM_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[pjd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[pjd_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(pjd_pkg::ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/pjd_cordic.sv =====
// Iterative rotation-mode CORDIC giving clamped |cos| and |sin| of a binary angle.
module pjd_cordic
#(
    parameter int CORDIC_STEPS = pjd_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pjd_pkg::HEAD_W-1:0]    angle,
    output logic                          done,
    output pjd_pkg::trig_t                trig
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int XY_W  = pjd_pkg::CORDIC_XY_W;
    localparam int Z_W   = pjd_pkg::CORDIC_Z_W;
    localparam int A_W   = pjd_pkg::HEAD_W - 1;

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [A_W-1:0]         fold;
    logic [pjd_pkg::HEAD_W-1:0] mirror;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  atan_val;

    always_comb
    begin
        // |cos| and |sin| repeat every half turn and mirror about the quarter turn.
        mirror = pjd_pkg::HALF_TURN - {1'b0, angle[A_W-1:0]};
        fold   = (angle[A_W-1:0] > pjd_pkg::QUARTER_TURN) ? mirror[A_W-1:0] : angle[A_W-1:0];

        x_sh     = x_reg >>> cnt_reg;
        y_sh     = y_reg >>> cnt_reg;
        atan_val = $signed(pjd_pkg::atan_entry(pjd_pkg::ATAN_IDX_W'(cnt_reg)));

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            x_next    = $signed(pjd_pkg::CORDIC_X0);
            y_next    = '0;
            z_next    = $signed(Z_W'({fold, 16'h0000}));
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_val;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_val;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Clamp both results to [0, 1.0] in Q1.30.
    always_comb
    begin
        if (x_reg[XY_W-1])
            trig.cos_mag = '0;
        else if ($unsigned(x_reg) > pjd_pkg::CORDIC_ONE)
            trig.cos_mag = pjd_pkg::CORDIC_ONE[pjd_pkg::TRIG_W-1:0];
        else
            trig.cos_mag = x_reg[pjd_pkg::TRIG_W-1:0];

        if (y_reg[XY_W-1])
            trig.sin_mag = '0;
        else if ($unsigned(y_reg) > pjd_pkg::CORDIC_ONE)
            trig.sin_mag = pjd_pkg::CORDIC_ONE[pjd_pkg::TRIG_W-1:0];
        else
            trig.sin_mag = y_reg[pjd_pkg::TRIG_W-1:0];
    end

    assign done = done_reg;

endmodule

// ===== hdl/pjd_checker.sv =====
// Port-level checker of the pose jump detector and its bind to the top level.
module pjd_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 jump,
    input logic                                 yaw_over,
    input logic                                 forward_over,
    input logic                                 lateral_over
);

    // The block works on one pose at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again straight after a beat");

    // A result cannot appear in the cycle after a pose is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared too early");

    // The summary flag is the OR of the three limit flags.
    a_jump_is_or: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (jump == (yaw_over || forward_over || lateral_over)))
        else $error("jump does not match the limit flags");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable({jump, yaw_over, forward_over, lateral_over})))
        else $error("stalled result changed");

endmodule

bind pose_jump_detector pjd_checker u_pjd_checker (.*);

// ===== test/pose_jump_detector_test.sv =====
// Self-checking testbench for pose_jump_detector: predicted jump flags compared beat by beat.
`timescale 1ns / 1ps

module pose_jump_detector_test;

    localparam int POS_W       = pjd_pkg::POS_W;
    localparam int HEAD_W      = pjd_pkg::HEAD_W;
    localparam int YAW_LIMIT_W = pjd_pkg::YAW_LIMIT_W;
    localparam int LIMIT_W     = pjd_pkg::LIMIT_W;
    localparam int CFG_IDX_W   = pjd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = pjd_pkg::CFG_DATA_W;

    // The block is built with its default number of CORDIC rotations; the
    // predictor below runs the same count.
    localparam int TRIG_STEPS = pjd_pkg::CORDIC_STEPS_DEF;

    // The spare register index has no register behind it and must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [LIMIT_W-1:0]      LIMIT_TOP = {LIMIT_W{1'b1}};

    // Roughly 1800 poses are sent in all, and the watchdog limit leaves a wide
    // margin for the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          POSES_PER_SETTING = 220;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic        [HEAD_W-1:0] heading;
        logic                     valid;
        logic                     too_long;
        logic                     wheel;
    } pose_t;

    typedef struct packed {
        logic jump;
        logic yaw_over;
        logic forward_over;
        logic lateral_over;
    } jump_flags_t;

    // Keeps its own copy of the limits and of the previous pose, works out the
    // flags each accepted pose should raise and checks the result beats in order.
    class jump_flag_scoreboard;
        logic [YAW_LIMIT_W-1:0] yaw_limit;
        logic [LIMIT_W-1:0]     forward_limit;
        logic [LIMIT_W-1:0]     lateral_limit;
        pose_t                  last;
        bit                     primed;
        jump_flags_t            flags_due[$];
        longint                 atan_step[24];
        int unsigned            poses, recoveries, yaw_hits, forward_hits, lateral_hits;
        int unsigned            failures;

        function new();
            yaw_limit     = pjd_pkg::YAW_LIMIT_RST;
            forward_limit = pjd_pkg::FORWARD_LIMIT_RST;
            lateral_limit = pjd_pkg::LATERAL_LIMIT_RST;
            last          = '0;
            primed        = 1'b0;
            atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                          333772, 166886, 83443, 41722, 20861, 10430, 5215,
                          2608, 1304, 652, 326, 163, 81};
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                pjd_pkg::REG_YAW_LIMIT:     yaw_limit = data[YAW_LIMIT_W-1:0];
                pjd_pkg::REG_FORWARD_LIMIT: forward_limit = data[LIMIT_W-1:0];
                pjd_pkg::REG_LATERAL_LIMIT: lateral_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(input longint unsigned n);
            longint unsigned r, trial;
            int              b;
            r = 0;
            for (b = 31; b >= 0; b--)
            begin
                trial = r | (64'd1 << b);
                if (trial * trial <= n)
                    r = trial;
            end
            return r;
        endfunction

        // |cos| and |sin| of a binary angle in Q1.30, folded into a quarter turn.
        function void heading_trig(input logic [HEAD_W-1:0] h,
                                   output longint unsigned c, output longint unsigned s);
            longint x, y, z, nx, quarter;
            int     i;
            quarter = h[HEAD_W-2:0];
            if (quarter > 16384)
                quarter = 32768 - quarter;
            z = quarter <<< 16;
            x = 652032874;
            y = 0;
            for (i = 0; i < TRIG_STEPS && i < 24; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_step[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_step[i];
                end
                x = nx;
            end
            if (x < 0)
                x = 0;
            if (y < 0)
                y = 0;
            if (x > (longint'(1) << 30))
                x = longint'(1) << 30;
            if (y > (longint'(1) << 30))
                y = longint'(1) << 30;
            c = x;
            s = y;
        endfunction

        function void note_pose(input pose_t p);
            jump_flags_t     f;
            logic [HEAD_W-1:0] turn;
            longint          dx, dy;
            longint unsigned span, c, s;
            if (!primed)
            begin
                last   = p;
                primed = 1'b1;
            end
            f = '0;
            poses++;
            if (!last.valid && last.too_long && last.wheel && p.valid && !p.wheel)
                recoveries++;
            else
            begin
                turn = p.heading - last.heading;
                if (turn > pjd_pkg::HALF_TURN)
                    turn = '0 - turn;
                f.yaw_over = turn > yaw_limit;
                dx = longint'($signed(p.x)) - longint'($signed(last.x));
                dy = longint'($signed(p.y)) - longint'($signed(last.y));
                span = root_floor(longint'(dx * dx) + longint'(dy * dy));
                heading_trig(last.heading, c, s);
                f.forward_over = ((span * c) >> 30) > forward_limit;
                f.lateral_over = ((span * s) >> 30) > lateral_limit;
            end
            f.jump = f.yaw_over | f.forward_over | f.lateral_over;
            yaw_hits     += f.yaw_over;
            forward_hits += f.forward_over;
            lateral_hits += f.lateral_over;
            last = p;
            flags_due.insert(flags_due.size(), f);
        endfunction

        function void compare_flag(input string name, input logic want, input logic got);
            if (got !== want)
            begin
                $error("%s: expected %0b, actual %0b", name, want, got);
                failures++;
            end
        endfunction

        function void check_flags(input jump_flags_t got);
            jump_flags_t want;
            if (flags_due.size() == 0)
            begin
                $error("result beat with no pose outstanding (jump=%0b)", got.jump);
                failures++;
                return;
            end
            want = flags_due[0];
            flags_due.delete(0);
            compare_flag("jump", want.jump, got.jump);
            compare_flag("yaw_over", want.yaw_over, got.yaw_over);
            compare_flag("forward_over", want.forward_over, got.forward_over);
            compare_flag("lateral_over", want.lateral_over, got.lateral_over);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;
    logic                     pose_valid;
    logic                     dead_reckon_too_long;
    logic                     from_wheel;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     jump;
    logic                     yaw_over;
    logic                     forward_over;
    logic                     lateral_over;

    jump_flag_scoreboard board;
    pose_t               recent;        // last pose handed to the block
    bit                  calm;          // when set, neither side idles
    int unsigned         cycles;
    int unsigned         settings;
    int unsigned         stall_left, run_left;

    pose_jump_detector #(.CORDIC_STEPS(TRIG_STEPS)) uut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .pos_x                (pos_x),
        .pos_y                (pos_y),
        .heading              (heading),
        .pose_valid           (pose_valid),
        .dead_reckon_too_long (dead_reckon_too_long),
        .from_wheel           (from_wheel),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .jump                 (jump),
        .yaw_over             (yaw_over),
        .forward_over         (forward_over),
        .lateral_over         (lateral_over)
    );

    // Free-running 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver. Unless calm is set, it alternates runs of readiness with stalls of
    // its own choosing; the occasional long stall can outlast a whole computation,
    // so the block has to hold a finished result while the next pose is under way.
    always @(posedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (run_left != 0)
        begin
            run_left--;
            out_ready <= 1'b1;
        end
        else
        begin
            run_left   = $urandom_range(0, 40);
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70)
                                                     : $urandom_range(0, 6);
            out_ready <= 1'b1;
        end
    end

    // Result beats are taken at the edge where out_valid and out_ready are both
    // high; the values read here are the ones the block saw before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_flags('{jump, yaw_over, forward_over, lateral_over});
    end

    function automatic pose_t pose_of(input longint x, input longint y, input int h,
                                      input bit v, input bit t, input bit w);
        pose_t p;
        p.x        = POS_W'(x);
        p.y        = POS_W'(y);
        p.heading  = HEAD_W'(h);
        p.valid    = v;
        p.too_long = t;
        p.wheel    = w;
        return p;
    endfunction

    // A coordinate near the previous one at a random scale, with now and then a
    // jump anywhere or to either end of the range. Overflow simply wraps.
    function automatic logic signed [POS_W-1:0] wander(input logic signed [POS_W-1:0] base);
        int unsigned pick, k;
        longint      delta;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return POS_W'($urandom);
        if (pick < 15)
            return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        k     = $urandom_range(0, 24);
        delta = longint'($urandom_range(0, 2 << k)) - (longint'(1) << k);
        return POS_W'(longint'($signed(base)) + delta);
    endfunction

    function automatic pose_t next_pose();
        pose_t       p;
        int unsigned pick, k;
        int          delta;
        bit          was_lost;
        was_lost = !recent.valid && recent.too_long && recent.wheel;
        p.x = wander(recent.x);
        p.y = wander(recent.y);

        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            case ($urandom_range(0, 4))
                0:       p.heading = 16'h0000;
                1:       p.heading = 16'h4000;
                2:       p.heading = 16'h8000;
                3:       p.heading = 16'hC000;
                default: p.heading = 16'h7FFF;
            endcase
        end
        else if (pick < 55)
        begin
            k     = $urandom_range(0, 15);
            delta = int'($urandom_range(0, 2 << k)) - (1 << k);
            p.heading = recent.heading + HEAD_W'(delta);
        end
        else
            p.heading = HEAD_W'($urandom);

        // Lost wheel poses are followed at least half the time by a code pose, which
        // is the recovery that must suppress every flag however far it lands.
        if (was_lost && $urandom_range(0, 1))
        begin
            p.valid    = 1'b1;
            p.too_long = 1'($urandom_range(0, 1));
            p.wheel    = 1'b0;
            p.x        = POS_W'($urandom);
            p.y        = POS_W'($urandom);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            p.valid    = 1'b0;
            p.too_long = 1'b1;
            p.wheel    = 1'b1;
        end
        else
        begin
            p.valid    = ($urandom_range(0, 4) != 0);
            p.too_long = ($urandom_range(0, 4) == 0);
            p.wheel    = 1'($urandom_range(0, 1));
        end
        return p;
    endfunction

    // Presents one pose and holds it until the input beat is taken.
    task automatic drive_pose(input pose_t p);
        in_valid             <= 1'b1;
        pos_x                <= p.x;
        pos_y                <= p.y;
        heading              <= p.heading;
        pose_valid           <= p.valid;
        dead_reckon_too_long <= p.too_long;
        from_wheel           <= p.wheel;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        board.note_pose(p);
        recent = p;
    endtask

    // Sends poses in bursts of random length separated by random gaps, none when calm.
    task automatic send_random_poses(input int count);
        int          left_in_burst;
        int unsigned gap, pick;
        left_in_burst = 0;
        repeat (count)
        begin
            if (left_in_burst == 0)
            begin
                left_in_burst = $urandom_range(1, 12);
                pick = $urandom_range(0, 9);
                if (calm || pick < 3)
                    gap = 0;
                else if (pick == 9)
                    gap = $urandom_range(20, 50);
                else
                    gap = $urandom_range(1, 8);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            drive_pose(next_pose());
            left_in_burst--;
        end
    endtask

    // Waits until every pose has produced its result beat. Each pose gives
    // exactly one result, so the block is idle once nothing is outstanding.
    task automatic wait_flags_drained();
        in_valid <= 1'b0;
        while (board.flags_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_port(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Writes all three limits, then random data to the spare index, which
    // must leave them untouched.
    task automatic program_limits(input logic [YAW_LIMIT_W-1:0] yaw,
                                  input logic [LIMIT_W-1:0] fwd, input logic [LIMIT_W-1:0] lat);
        write_port(pjd_pkg::REG_YAW_LIMIT, CFG_DATA_W'(yaw));
        write_port(pjd_pkg::REG_FORWARD_LIMIT, CFG_DATA_W'(fwd));
        write_port(pjd_pkg::REG_LATERAL_LIMIT, CFG_DATA_W'(lat));
        write_port(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        pose_t opening[$];

        board      = new();
        recent     = '0;
        calm       = 1'b0;
        cycles     = 0;
        settings   = 1;
        stall_left = 0;
        run_left   = 0;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_wdata            <= '0;
        in_valid             <= 1'b0;
        pos_x                <= '0;
        pos_y                <= '0;
        heading              <= '0;
        pose_valid           <= 1'b0;
        dead_reckon_too_long <= 1'b0;
        from_wheel           <= 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed poses at the reset limits: the first pose compared with
        // itself, moves and turns just either side of the limits, heading wrap
        // and the half-turn difference, the folded quadrants of the previous
        // heading, the full span of both axes, and recovery from dead
        // reckoning next to poses that only nearly qualify for it.
        opening = '{
            pose_of(1000000, -5000, 20000, 1, 0, 0),
            pose_of(1000000, -5000, 20000, 1, 0, 0),
            pose_of(0, 0, 0, 1, 0, 0),
            pose_of(2048, 0, 0, 1, 0, 0),
            pose_of(4097, 0, 0, 1, 0, 0),
            pose_of(4097, 0, 1820, 1, 0, 0),
            pose_of(4097, 0, 3641, 1, 0, 0),
            pose_of(4097, 0, 16384, 1, 0, 0),
            pose_of(4097, 3000, 16384, 1, 0, 0),
            pose_of(4097, 3000, 32767, 1, 0, 0),
            pose_of(4097, 3000, -32768, 1, 0, 0),
            pose_of(4097, 3000, 0, 1, 0, 0),
            pose_of(4097, 3000, -16384, 1, 0, 0),
            pose_of(POS_MIN, POS_MIN, 0, 1, 0, 0),
            pose_of(POS_MAX, POS_MAX, 12345, 1, 1, 1),
            pose_of(POS_MAX, POS_MIN, -1, 0, 1, 1),
            pose_of(POS_MIN, POS_MAX, 30000, 1, 0, 0),
            pose_of(0, 0, 0, 0, 1, 1),
            pose_of(500000, 0, 9000, 1, 0, 1),
            pose_of(500000, 0, 9000, 0, 0, 0),
            pose_of(0, 0, -9000, 1, 1, 0)
        };
        foreach (opening[i])
            drive_pose(opening[i]);
        wait_flags_drained();

        // Random traffic, first at the reset limits, then at the extremes: zero limits,
        // top limits under which no turn flags, and a yaw limit beyond a half turn.
        send_random_poses(POSES_PER_SETTING);
        wait_flags_drained();

        program_limits('0, '0, '0);
        calm = 1'b1;
        send_random_poses(POSES_PER_SETTING);
        wait_flags_drained();

        program_limits(YAW_LIMIT_W'(32768), LIMIT_TOP, LIMIT_TOP);
        calm = 1'b0;
        send_random_poses(POSES_PER_SETTING);
        wait_flags_drained();

        program_limits({YAW_LIMIT_W{1'b1}}, '0, LIMIT_TOP);
        send_random_poses(POSES_PER_SETTING);
        wait_flags_drained();

        // Limits at random scales, so that the random steps land on both sides.
        repeat (4)
        begin
            program_limits(YAW_LIMIT_W'($urandom_range(0, 32768)),
                           LIMIT_W'($urandom_range(0, 1 << $urandom_range(0, 30))),
                           LIMIT_W'($urandom_range(0, 1 << $urandom_range(0, 30))));
            calm = ($urandom_range(0, 2) == 0);
            send_random_poses(POSES_PER_SETTING);
            wait_flags_drained();
        end

        // Leave time for any stray result beat to show up.
        repeat (60) @(posedge clk);

        $display("Checked %0d poses over %0d limit settings, %0d of them recoveries.",
                 board.poses, settings, board.recoveries);
        $display("Flags seen: yaw %0d, forward %0d, lateral %0d; %0d mismatches.",
                 board.yaw_hits, board.forward_hits, board.lateral_hits, board.failures);
        if (board.failures == 0 && board.flags_due.size() == 0)
            $display("tb: success");
        else
        begin
            if (board.flags_due.size() != 0)
                $error("%0d results never arrived", board.flags_due.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
